FILE: sv/uer_pkg.sv
// Shared types, register indexes and constants for the three-channel echo ranger.
`default_nettype none

package uer_pkg;

  localparam int CHANNELS_DEF = 3;
  localparam int CNT_BITS_DEF = 16;
  localparam int CHAN_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int DIST_W       = 14;
  localparam int WIDTH_W      = 16;

  // width*10/58 == width*5/29, done as a multiply by a scaled reciprocal
  localparam int DIST_MUL_W   = 19;
  localparam logic [DIST_MUL_W-1:0] DIST_MUL = DIST_MUL_W'(361578);
  localparam int DIST_SHIFT   = 21;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_W   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_W   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP     = 3'd4;

  localparam logic [7:0]  TRIGGER_RST = 8'd1;
  localparam logic [15:0] TIMEOUT_RST = 16'd6000;
  localparam logic [15:0] MIN_W_RST   = 16'd5;
  localparam logic [15:0] MAX_W_RST   = 16'd3540;
  localparam logic [15:0] GAP_RST     = 16'd1000;

  localparam logic [CHAN_W-1:0] CH_FRONT = 2'd0;
  localparam logic [CHAN_W-1:0] CH_LEFT  = 2'd1;
  localparam logic [CHAN_W-1:0] CH_RIGHT = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TRIG = 3'd1,
    PH_RISE = 3'd2,
    PH_HIGH = 3'd3,
    PH_GAP  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RISE  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } command_e;

  typedef struct packed {
    logic command;
    logic echo_front;
    logic echo_left;
    logic echo_right;
  } in_item_t;

  typedef struct packed {
    logic              trig_front;
    logic              trig_left;
    logic              trig_right;
    logic              reading_valid;
    logic [CHAN_W-1:0] reading_channel;
    logic [DIST_W-1:0] range_cm;
    status_e           status;
    logic              busy_res;
    logic              sweep_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [15:0] timeout_ticks;
    logic [15:0] min_width_ticks;
    logic [15:0] max_width_ticks;
    logic [15:0] gap_ticks;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/ultrasonic_echo_ranger_3ch.sv
// Top level of the three-channel ultrasonic echo ranger.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_ready_o   in_data_i  (uer_pkg::in_item_t)
//  out      output     out_valid_o/out_ready_i out_data_o (uer_pkg::out_item_t)
//  cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One item per clock while the output side takes results. The state update and the
// result are formed in the cycle of the input transfer and held in the output register.
// in_ready_o is high while the output register is empty or being taken, so a
// stall on the output side holds the input side after one waiting result.
// Reset loads the register defaults and leaves the sweep idle on channel front.
`default_nettype none

module ultrasonic_echo_ranger_3ch #(
  parameter int CHANNEL_COUNT = uer_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS  = uer_pkg::CNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  uer_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output uer_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import uer_pkg::*;

  cfg_t      cfg;
  out_item_t res;
  out_item_t out_q;
  logic      out_valid_q;
  logic      fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  uer_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  uer_ctrl #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/uer_cfg_regs.sv
// Configuration register file for the echo ranger.
`default_nettype none

module uer_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output uer_pkg::cfg_t                  cfg_o
);
  import uer_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks   <= TRIGGER_RST;
      cfg_q.timeout_ticks   <= TIMEOUT_RST;
      cfg_q.min_width_ticks <= MIN_W_RST;
      cfg_q.max_width_ticks <= MAX_W_RST;
      cfg_q.gap_ticks       <= GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRIGGER: cfg_q.trigger_ticks   <= cfg_wdata_i[7:0];
        REG_TIMEOUT: cfg_q.timeout_ticks   <= cfg_wdata_i;
        REG_MIN_W:   cfg_q.min_width_ticks <= cfg_wdata_i;
        REG_MAX_W:   cfg_q.max_width_ticks <= cfg_wdata_i;
        REG_GAP:     cfg_q.gap_ticks       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: sv/uer_dist.sv
// Echo width to distance conversion by reciprocal multiply.
`default_nettype none

module uer_dist (
  input  logic [uer_pkg::WIDTH_W-1:0] width_i,
  output logic [uer_pkg::DIST_W-1:0]  dist_o
);
  import uer_pkg::*;

  localparam int PROD_W = WIDTH_W + DIST_MUL_W;

  logic [PROD_W-1:0] prod;

  assign prod   = PROD_W'(width_i) * PROD_W'(DIST_MUL);
  assign dist_o = prod[DIST_SHIFT +: DIST_W];

endmodule

`default_nettype wire

FILE: sv/uer_ctrl.sv
// Sweep state machine, tick counter and result formation.
`default_nettype none

module uer_ctrl #(
  parameter int CHANNEL_COUNT = uer_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS  = uer_pkg::CNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  uer_pkg::in_item_t  item_i,
  input  uer_pkg::cfg_t      cfg_i,
  output uer_pkg::out_item_t res_o
);
  import uer_pkg::*;

  localparam int CMP_W = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  phase_e                  phase_q, phase_d;
  logic [CHAN_W-1:0]       chan_q, chan_d;
  logic [COUNTER_BITS-1:0] tick_q, tick_d;
  logic [COUNTER_BITS-1:0] tick_inc;
  logic                    echo;
  logic                    finish;
  logic                    dist_en;
  logic                    done;
  logic                    last_chan;
  status_e                 status;
  logic [DIST_W-1:0]       range_val;

  assign tick_inc  = (tick_q == CNT_MAX) ? tick_q : tick_q + 1'b1;
  assign last_chan = !(({1'b0, chan_q} + 3'd1) < 3'(CHANNEL_COUNT));

  always_comb begin
    case (chan_q)
      CH_FRONT: echo = item_i.echo_front;
      CH_LEFT:  echo = item_i.echo_left;
      CH_RIGHT: echo = item_i.echo_right;
      default:  echo = 1'b0;
    endcase
  end

  uer_dist u_dist (
    .width_i (WIDTH_W'(tick_q)),
    .dist_o  (range_val)
  );

  always_comb begin
    phase_d = phase_q;
    chan_d  = chan_q;
    tick_d  = tick_q;
    finish  = 1'b0;
    dist_en = 1'b0;
    done    = 1'b0;
    status  = ST_OK;
    if (item_i.command == CMD_START) begin
      if (phase_q == PH_IDLE) begin
        chan_d  = CH_FRONT;
        tick_d  = '0;
        phase_d = PH_TRIG;
      end
    end else begin
      case (phase_q)
        PH_TRIG: begin
          tick_d = tick_inc;
          if (CMP_W'(tick_inc) >= CMP_W'(cfg_i.trigger_ticks)) begin
            phase_d = PH_RISE;
            tick_d  = '0;
          end
        end
        PH_RISE: begin
          if (echo) begin
            phase_d = PH_HIGH;
            tick_d  = COUNTER_BITS'(1);
          end else if (CMP_W'(tick_q) >= CMP_W'(cfg_i.timeout_ticks)) begin
            finish = 1'b1;
            status = ST_NO_RISE;
          end else begin
            tick_d = tick_inc;
          end
        end
        PH_HIGH: begin
          if (echo) begin
            if (CMP_W'(tick_q) >= CMP_W'(cfg_i.timeout_ticks)) begin
              finish = 1'b1;
              status = ST_TOO_LONG;
            end else begin
              tick_d = tick_inc;
            end
          end else begin
            finish = 1'b1;
            if (CMP_W'(tick_q) < CMP_W'(cfg_i.min_width_ticks) ||
                CMP_W'(tick_q) > CMP_W'(cfg_i.max_width_ticks)) begin
              status = ST_RANGE;
            end else begin
              dist_en = 1'b1;
            end
          end
        end
        PH_GAP: begin
          if (CMP_W'(tick_q) >= CMP_W'(cfg_i.gap_ticks)) begin
            chan_d  = chan_q + 1'b1;
            tick_d  = '0;
            phase_d = PH_TRIG;
          end else begin
            tick_d = tick_inc;
          end
        end
        default: ;
      endcase
    end
    if (finish) begin
      tick_d = '0;
      if (last_chan) begin
        phase_d = PH_IDLE;
        chan_d  = CH_FRONT;
        done    = 1'b1;
      end else begin
        phase_d = PH_GAP;
      end
    end
  end

  always_comb begin
    res_o.trig_front      = (phase_d == PH_TRIG) && (chan_d == CH_FRONT);
    res_o.trig_left       = (phase_d == PH_TRIG) && (chan_d == CH_LEFT);
    res_o.trig_right      = (phase_d == PH_TRIG) && (chan_d == CH_RIGHT);
    res_o.reading_valid   = finish;
    res_o.reading_channel = finish ? chan_q : chan_d;
    res_o.range_cm        = dist_en ? range_val : '0;
    res_o.status          = status;
    res_o.busy_res        = (phase_d != PH_IDLE);
    res_o.sweep_done      = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      chan_q  <= CH_FRONT;
      tick_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      tick_q  <= tick_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/uer_checker.sv
// Port-level checks for the echo ranger and their binding to the top level.
`default_nettype none

module uer_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input uer_pkg::out_item_t             out_data_o
);
  import uer_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("input transfer gave no result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sweep_done |->
      out_data_o.reading_valid && !out_data_o.busy_res)
    else $error("sweep end without reading or still busy");

  a_no_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.reading_valid |->
      out_data_o.range_cm == '0 && out_data_o.status == ST_OK)
    else $error("distance or status without a reading");

  a_one_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.trig_front, out_data_o.trig_left,
                              out_data_o.trig_right}))
    else $error("more than one trigger driven");

endmodule

bind ultrasonic_echo_ranger_3ch uer_checker u_uer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: tb/sv/ultrasonic_echo_ranger_3ch_tb.sv
// Self-checking testbench for the three-channel ultrasonic echo ranger.
module ultrasonic_echo_ranger_3ch_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uer_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned NOISE_PCT   = 10;

  class echo_sweep_tracker;
    cfg_t        regs;
    phase_e      phase;
    logic [1:0]  chan;
    logic [15:0] ticks;
    out_item_t   pending_readings[$];
    int unsigned mismatches;
    int unsigned readings_seen;

    function new();
      regs = '{TRIGGER_RST, TIMEOUT_RST, MIN_W_RST, MAX_W_RST, GAP_RST};
      phase = PH_IDLE;
      chan = CH_FRONT;
      ticks = '0;
      mismatches = 0;
      readings_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TRIGGER: regs.trigger_ticks = val[7:0];
        REG_TIMEOUT: regs.timeout_ticks = val;
        REG_MIN_W:   regs.min_width_ticks = val;
        REG_MAX_W:   regs.max_width_ticks = val;
        REG_GAP:     regs.gap_ticks = val;
        default: ;
      endcase
    endfunction

    function void bump();
      if (ticks != '1) ticks++;
    endfunction

    function void take_item(in_item_t it);
      out_item_t  r;
      logic       echo;
      logic       finish;
      logic [1:0] done_ch;
      r = '0;
      r.status = ST_OK;
      finish = 1'b0;
      case (chan)
        CH_FRONT: echo = it.echo_front;
        CH_LEFT:  echo = it.echo_left;
        CH_RIGHT: echo = it.echo_right;
        default:  echo = 1'b0;
      endcase
      if (it.command == CMD_START) begin
        if (phase == PH_IDLE) begin
          chan = CH_FRONT;
          ticks = '0;
          phase = PH_TRIG;
        end
      end else begin
        case (phase)
          PH_TRIG: begin
            bump();
            if (ticks >= regs.trigger_ticks) begin
              phase = PH_RISE;
              ticks = '0;
            end
          end
          PH_RISE: begin
            if (echo) begin
              phase = PH_HIGH;
              ticks = 16'd1;
            end else if (ticks >= regs.timeout_ticks) begin
              finish = 1'b1;
              r.status = ST_NO_RISE;
            end else begin
              bump();
            end
          end
          PH_HIGH: begin
            if (echo) begin
              if (ticks >= regs.timeout_ticks) begin
                finish = 1'b1;
                r.status = ST_TOO_LONG;
              end else begin
                bump();
              end
            end else begin
              finish = 1'b1;
              if (ticks < regs.min_width_ticks || ticks > regs.max_width_ticks) begin
                r.status = ST_RANGE;
              end else begin
                r.range_cm = DIST_W'((32'(ticks) * 10) / 58);
              end
            end
          end
          PH_GAP: begin
            if (ticks >= regs.gap_ticks) begin
              chan = chan + 2'd1;
              ticks = '0;
              phase = PH_TRIG;
            end else begin
              bump();
            end
          end
          default: ;
        endcase
      end
      done_ch = chan;
      if (finish) begin
        r.reading_valid = 1'b1;
        ticks = '0;
        if (int'(chan) + 1 < CHANNELS_DEF) begin
          phase = PH_GAP;
        end else begin
          phase = PH_IDLE;
          chan = CH_FRONT;
          r.sweep_done = 1'b1;
        end
      end
      r.trig_front = (phase == PH_TRIG) && (chan == CH_FRONT);
      r.trig_left = (phase == PH_TRIG) && (chan == CH_LEFT);
      r.trig_right = (phase == PH_TRIG) && (chan == CH_RIGHT);
      r.reading_channel = finish ? done_ch : chan;
      r.busy_res = (phase != PH_IDLE);
      pending_readings.push_back(r);
    endfunction

    function void compare_reading(out_item_t got);
      out_item_t want;
      string     field;
      want = 'x;
      field = "";
      if (pending_readings.size() == 0) begin
        field = "unexpected transfer";
      end else begin
        want = pending_readings.pop_front();
        if (got.trig_front !== want.trig_front) field = "trig_front";
        else if (got.trig_left !== want.trig_left) field = "trig_left";
        else if (got.trig_right !== want.trig_right) field = "trig_right";
        else if (got.reading_valid !== want.reading_valid) field = "reading_valid";
        else if (got.reading_channel !== want.reading_channel) field = "reading_channel";
        else if (got.range_cm !== want.range_cm) field = "range_cm";
        else if (got.status !== want.status) field = "status";
        else if (got.busy_res !== want.busy_res) field = "busy_res";
        else if (got.sweep_done !== want.sweep_done) field = "sweep_done";
      end
      if (field != "") begin
        mismatches++;
        if (mismatches <= 10)
          $display("reading %0d: %s, expected %h, actual %h", readings_seen, field, want, got);
      end
      readings_seen++;
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  echo_sweep_tracker tracker;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;

  bit          plan_live = 1'b0;
  bit          plan_noisy = 1'b0;
  bit          long_mode = 1'b0;
  int unsigned plan_pos;
  int unsigned plan_delay;
  int unsigned plan_width;
  int unsigned long_width [3] = '{300, 1, 2};

  ultrasonic_echo_ranger_3ch u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next ready level
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) tracker.compare_reading(out_data_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic in_item_t make_item(command_e c, logic f, logic l, logic r);
    in_item_t it;
    it.command = c;
    it.echo_front = f;
    it.echo_left = l;
    it.echo_right = r;
    return it;
  endfunction

  task automatic push_input(input in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    tracker.take_item(it);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(input cfg_t c, input logic [7:0] junk);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] vals [5];
    idx = '{REG_TRIGGER, REG_TIMEOUT, REG_MIN_W, REG_MAX_W, REG_GAP};
    vals = '{{junk, c.trigger_ticks}, c.timeout_ticks, c.min_width_ticks,
             c.max_width_ticks, c.gap_ticks};
    for (int k = 0; k < 5; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[k];
      cfg_wdata_i <= vals[k];
      @(posedge clk_i);
      tracker.write_reg(idx[k], vals[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic void pick_echo_plan();
    int unsigned tmo;
    int unsigned w;
    tmo = tracker.regs.timeout_ticks;
    plan_live = 1'b1;
    plan_pos = 0;
    if (long_mode) begin
      plan_noisy = 1'b0;
      plan_delay = 0;
      plan_width = long_width[tracker.chan];
      return;
    end
    plan_noisy = ($urandom_range(99) < NOISE_PCT);
    case ($urandom_range(9))
      7: plan_delay = tmo;
      8: plan_delay = tmo + 1;
      default: plan_delay = $urandom_range(tmo < 4 ? tmo : 4);
    endcase
    case ($urandom_range(9))
      0: w = (tracker.regs.min_width_ticks == 0) ? 1 : tracker.regs.min_width_ticks - 1;
      1: w = tracker.regs.min_width_ticks;
      2: w = tracker.regs.max_width_ticks;
      3: w = tracker.regs.max_width_ticks + 1;
      4: w = tmo;
      5: w = tmo + 1;
      default: w = $urandom_range(tmo + 1, 1);
    endcase
    if (w < 1) w = 1;
    if (w > tmo + 1) w = tmo + 1;
    plan_width = w;
  endfunction

  task automatic compose_item(input bit opening, output in_item_t it);
    logic lvl;
    it = make_item(CMD_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
    if (tracker.phase == PH_IDLE) begin
      plan_live = 1'b0;
      if (opening && $urandom_range(3) != 0) it.command = CMD_START;
    end else begin
      if ($urandom_range(39) == 0) it.command = CMD_START;
      if (tracker.phase == PH_RISE || tracker.phase == PH_HIGH) begin
        if (!plan_live) pick_echo_plan();
        if (!plan_noisy) begin
          lvl = (plan_pos >= plan_delay) && (plan_pos < plan_delay + plan_width);
          case (tracker.chan)
            CH_FRONT: it.echo_front = lvl;
            CH_LEFT:  it.echo_left = lvl;
            default:  it.echo_right = lvl;
          endcase
        end
        if (it.command == CMD_TICK) plan_pos++;
      end else begin
        plan_live = 1'b0;
      end
    end
  endtask

  // start sweeps until enough items have counted, then finish the open sweep
  task automatic run_sweeps(input int unsigned n_items);
    in_item_t    it;
    int unsigned counted;
    bit          opening;
    counted = 0;
    while (counted < n_items || tracker.phase != PH_IDLE) begin
      opening = (counted < n_items);
      compose_item(opening, it);
      if ((tracker.phase == PH_IDLE) == (it.command == CMD_START)) counted++;
      push_input(it);
    end
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TRIGGER;
    cfg_wdata_i = '0;
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    program_regs('{8'd1, 16'd2, 16'd2, 16'd2, 16'd0}, 8'h00);
    push_input(make_item(CMD_TICK,  1'b1, 1'b1, 1'b1));
    push_input(make_item(CMD_START, 1'b1, 1'b1, 1'b1));
    push_input(make_item(CMD_START, 1'b0, 1'b0, 1'b0));
    push_input(make_item(CMD_TICK,  1'b0, 1'b0, 1'b0));
    push_input(make_item(CMD_TICK,  1'b0, 1'b0, 1'b0));
    push_input(make_item(CMD_TICK,  1'b0, 1'b0, 1'b0));
    push_input(make_item(CMD_TICK,  1'b0, 1'b1, 1'b1));
    push_input(make_item(CMD_TICK,  1'b1, 1'b1, 1'b1));
    push_input(make_item(CMD_TICK,  1'b0, 1'b0, 1'b0));
    push_input(make_item(CMD_START, 1'b1, 1'b1, 1'b1));
    push_input(make_item(CMD_TICK,  1'b0, 1'b1, 1'b0));
    push_input(make_item(CMD_TICK,  1'b0, 1'b1, 1'b0));
    push_input(make_item(CMD_TICK,  1'b0, 1'b1, 1'b0));
    push_input(make_item(CMD_TICK,  1'b0, 1'b0, 1'b0));
    push_input(make_item(CMD_TICK,  1'b0, 1'b0, 1'b0));
    push_input(make_item(CMD_TICK,  1'b0, 1'b0, 1'b1));
    push_input(make_item(CMD_TICK,  1'b1, 1'b1, 1'b0));
    push_input(make_item(CMD_START, 1'b0, 1'b0, 1'b0));
    push_input(make_item(CMD_TICK,  1'b0, 1'b0, 1'b0));
    push_input(make_item(CMD_TICK,  1'b1, 1'b0, 1'b0));
    push_input(make_item(CMD_TICK,  1'b1, 1'b0, 1'b0));
    push_input(make_item(CMD_TICK,  1'b0, 1'b1, 1'b1));
    run_sweeps(0);

    program_regs('{8'd1, 16'd12, 16'd3, 16'd8, 16'd2}, 8'h00);
    run_sweeps(120);

    src_idle_pct = 65;
    program_regs('{8'd3, 16'd20, 16'd0, 16'd15, 16'd5}, 8'h00);
    run_sweeps(120);

    src_idle_pct = 0;
    sink_stall_pct = 65;
    program_regs('{8'd2, 16'd1, 16'd0, 16'd0, 16'd1}, 8'hA5);
    run_sweeps(120);

    src_idle_pct = 29;
    sink_stall_pct = 29;
    program_regs('{8'd1, 16'd30, 16'd10, 16'd25, 16'd3}, 8'h00);
    hold_req = 1'b1;
    run_sweeps(120);

    src_idle_pct = 0;
    sink_stall_pct = 0;
    long_mode = 1'b1;
    program_regs('{8'd60, 16'd65535, 16'd0, 16'd65535, 16'd0}, 8'h00);
    run_sweeps(1);
    long_mode = 1'b0;

    src_idle_pct = 29;
    sink_stall_pct = 29;
    program_regs('{8'd1, 16'd1, 16'd65535, 16'd0, 16'd0}, 8'hFF);
    run_sweeps(120);

    repeat (5) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_readings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/uer_pkg.sv
sv/uer_cfg_regs.sv
sv/uer_dist.sv
sv/uer_ctrl.sv
sv/ultrasonic_echo_ranger_3ch.sv
sv/uer_checker.sv
tb/sv/ultrasonic_echo_ranger_3ch_tb.sv
